### design/npec_pkg.sv
`timescale 1ns / 1ps

package npec_pkg;

  localparam int SECTOR_BYTES     = 512;
  localparam int SECTORS_PER_PAGE = 4;

  localparam int BYTE_IDX_W   = $clog2(SECTOR_BYTES);
  localparam int SECTOR_IDX_W = (SECTORS_PER_PAGE > 1) ? $clog2(SECTORS_PER_PAGE) : 1;
  localparam int COUNT_W      = 3;
  localparam int HALF_W       = 12;

  localparam logic [31:0]        ERASED_WORD = 32'hFFFF_FFFF;
  localparam logic [HALF_W-1:0]  HALF_MASK   = 12'hfff;
  localparam logic [COUNT_W-1:0] COUNT_MAX   = 3'd7;

  localparam logic MODE_ECC  = 1'b0;
  localparam logic MODE_DATA = 1'b1;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_CORRECTED = 2'd1;
  localparam logic [1:0] STATUS_FAILED    = 2'd2;

  typedef struct packed {
    logic [7:0]         data_out;
    logic               last;
    logic [1:0]         page_status;
    logic [COUNT_W-1:0] corrected_count;
    logic [COUNT_W-1:0] uncorrectable_count;
  } result_t;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    sat_inc = (v == COUNT_MAX) ? COUNT_MAX : v + COUNT_W'(1);
  endfunction

endpackage

### design/nand_page_ecc_corrector.sv
`timescale 1ns / 1ps

// channel   handshake                     payload
// input     in_valid / in_stall           mode, ecc_stored, ecc_computed, data_byte
// output    out_valid / out_stall         data_out, last, page_status,
//                                         corrected_count, uncorrectable_count
//
// one word per cycle while in_stall is low: judging and the bit flip sit
// between the input port and the output register, which holds the result
// a skid register behind the output register absorbs one word of output stall;
// in_stall rises only while the skid register is full
// rst is synchronous, active high, and clears all page and handshake state

module nand_page_ecc_corrector (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          mode,
  input  logic [31:0]                   ecc_stored,
  input  logic [31:0]                   ecc_computed,
  input  logic [7:0]                    data_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    data_out,
  output logic                          last,
  output logic [1:0]                    page_status,
  output logic [npec_pkg::COUNT_W-1:0]  corrected_count,
  output logic [npec_pkg::COUNT_W-1:0]  uncorrectable_count
);

  logic                                 flip_pending;
  logic [npec_pkg::HALF_W-1:0]          flip_position;
  logic [npec_pkg::BYTE_IDX_W-1:0]      byte_index;
  logic [npec_pkg::SECTOR_IDX_W-1:0]    sector_index;
  logic [npec_pkg::COUNT_W-1:0]         fixed_sectors;
  logic [npec_pkg::COUNT_W-1:0]         failed_sectors;

  logic                                 flip_pending_next;
  logic [npec_pkg::HALF_W-1:0]          flip_position_next;
  logic [npec_pkg::BYTE_IDX_W-1:0]      byte_index_next;
  logic [npec_pkg::SECTOR_IDX_W-1:0]    sector_index_next;
  logic [npec_pkg::COUNT_W-1:0]         fixed_sectors_next;
  logic [npec_pkg::COUNT_W-1:0]         failed_sectors_next;

  npec_pkg::result_t                    out_reg;
  npec_pkg::result_t                    skid_reg;
  npec_pkg::result_t                    res_next;
  logic                                 skid_valid;

  logic                                 accept;
  logic                                 res_fire;
  logic [31:0]                          syn;
  logic [npec_pkg::HALF_W-1:0]          even_half;
  logic [npec_pkg::HALF_W-1:0]          odd_half;
  logic                                 no_error;
  logic                                 single_bit;
  logic                                 halves_ok;
  logic                                 sector_end;
  logic                                 page_end;
  logic                                 hit;

  assign accept   = in_valid && !in_stall;
  assign res_fire = accept && (mode == npec_pkg::MODE_DATA);
  assign in_stall = skid_valid;

  // syndrome and its byte-swapped halves
  assign syn        = ecc_stored ^ ecc_computed;
  assign even_half  = {syn[19:16], syn[31:24]};
  assign odd_half   = {syn[3:0], syn[15:8]};
  assign no_error   = (ecc_stored == npec_pkg::ERASED_WORD) || (syn == 32'd0);
  assign single_bit = ((syn & (syn - 32'd1)) == 32'd0);
  assign halves_ok  = ((even_half ^ odd_half) == npec_pkg::HALF_MASK);

  assign sector_end = (byte_index == npec_pkg::BYTE_IDX_W'(npec_pkg::SECTOR_BYTES - 1));
  assign page_end   = sector_end &&
                      (sector_index == npec_pkg::SECTOR_IDX_W'(npec_pkg::SECTORS_PER_PAGE - 1));
  assign hit        = flip_pending && (flip_position[npec_pkg::HALF_W-1:3] == byte_index);

  always_comb begin
    flip_pending_next   = flip_pending;
    flip_position_next  = flip_position;
    byte_index_next     = byte_index;
    sector_index_next   = sector_index;
    fixed_sectors_next  = fixed_sectors;
    failed_sectors_next = failed_sectors;

    res_next.data_out            = data_byte;
    res_next.last                = 1'b0;
    res_next.page_status         = npec_pkg::STATUS_OK;
    res_next.corrected_count     = '0;
    res_next.uncorrectable_count = '0;

    if (hit) begin
      res_next.data_out = data_byte ^ (8'd1 << flip_position[2:0]);
    end

    if (mode == npec_pkg::MODE_ECC) begin
      flip_pending_next = 1'b0;
      if (!no_error) begin
        priority if (single_bit) begin
          fixed_sectors_next = npec_pkg::sat_inc(fixed_sectors);
        end else if (!halves_ok) begin
          failed_sectors_next = npec_pkg::sat_inc(failed_sectors);
        end else begin
          flip_pending_next  = 1'b1;
          flip_position_next = odd_half;
          fixed_sectors_next = npec_pkg::sat_inc(fixed_sectors);
        end
      end
    end else if (sector_end) begin
      byte_index_next   = '0;
      flip_pending_next = 1'b0;
      if (page_end) begin
        res_next.last                = 1'b1;
        res_next.corrected_count     = fixed_sectors;
        res_next.uncorrectable_count = failed_sectors;
        priority if (failed_sectors != '0) begin
          res_next.page_status = npec_pkg::STATUS_FAILED;
        end else if (fixed_sectors != '0) begin
          res_next.page_status = npec_pkg::STATUS_CORRECTED;
        end else begin
          res_next.page_status = npec_pkg::STATUS_OK;
        end
        sector_index_next   = '0;
        fixed_sectors_next  = '0;
        failed_sectors_next = '0;
      end else begin
        sector_index_next = sector_index + npec_pkg::SECTOR_IDX_W'(1);
      end
    end else begin
      byte_index_next = byte_index + npec_pkg::BYTE_IDX_W'(1);
    end
  end

  // page state
  always_ff @(posedge clk) begin
    if (rst) begin
      flip_pending   <= 1'b0;
      flip_position  <= '0;
      byte_index     <= '0;
      sector_index   <= '0;
      fixed_sectors  <= '0;
      failed_sectors <= '0;
    end else if (accept) begin
      flip_pending   <= flip_pending_next;
      flip_position  <= flip_position_next;
      byte_index     <= byte_index_next;
      sector_index   <= sector_index_next;
      fixed_sectors  <= fixed_sectors_next;
      failed_sectors <= failed_sectors_next;
    end
  end

  // output register with skid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid) begin
      if (res_fire) begin
        out_reg   <= res_next;
        out_valid <= 1'b1;
      end
    end else if (!out_stall) begin
      if (skid_valid) begin
        out_reg    <= skid_reg;
        skid_valid <= 1'b0;
      end else if (res_fire) begin
        out_reg <= res_next;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (res_fire) begin
      skid_reg   <= res_next;
      skid_valid <= 1'b1;
    end
  end

  assign data_out            = out_reg.data_out;
  assign last                = out_reg.last;
  assign page_status         = out_reg.page_status;
  assign corrected_count     = out_reg.corrected_count;
  assign uncorrectable_count = out_reg.uncorrectable_count;

`ifndef NO_ASSERTIONS
  a_skid_behind_out : assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid word held without output word");

  a_stalled_word_kept : assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_reg)))
    else $error("stalled output word lost or changed");

  a_status_only_at_last : assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last) |-> (page_status == npec_pkg::STATUS_OK &&
                              corrected_count == '0 && uncorrectable_count == '0))
    else $error("page status outside last word");

  a_failed_status : assert property (@(posedge clk) disable iff (rst)
    (out_valid && last && uncorrectable_count != '0) |->
      (page_status == npec_pkg::STATUS_FAILED))
    else $error("uncorrectable page not flagged");

  a_no_flip_past_sector : assert property (@(posedge clk) disable iff (rst)
    (accept && mode == npec_pkg::MODE_DATA && sector_end) |=> !flip_pending)
    else $error("flip carried into next sector");
`endif

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        in_valid = 1'b0;
  logic        mode = npec_pkg::MODE_DATA;
  logic [31:0] ecc_stored = '0;
  logic [31:0] ecc_computed = '0;
  logic [7:0]  data_byte = '0;
  logic        out_stall = 1'b0;

  logic                         in_stall;
  logic                         out_valid;
  logic [7:0]                   data_out;
  logic                         last;
  logic [1:0]                   page_status;
  logic [npec_pkg::COUNT_W-1:0] corrected_count;
  logic [npec_pkg::COUNT_W-1:0] uncorrectable_count;

  nand_page_ecc_corrector dut (
    .clk                 (clk),
    .rst                 (rst),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .mode                (mode),
    .ecc_stored          (ecc_stored),
    .ecc_computed        (ecc_computed),
    .data_byte           (data_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .data_out            (data_out),
    .last                (last),
    .page_status         (page_status),
    .corrected_count     (corrected_count),
    .uncorrectable_count (uncorrectable_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // page state as the corrector should hold it
  logic                              flip_due = 1'b0;
  logic [npec_pkg::HALF_W-1:0]       flip_at = '0;
  logic [npec_pkg::BYTE_IDX_W-1:0]   byte_pos = '0;
  logic [npec_pkg::SECTOR_IDX_W-1:0] sector_pos = '0;
  logic [npec_pkg::COUNT_W-1:0]      nfixed = '0;
  logic [npec_pkg::COUNT_W-1:0]      nfailed = '0;

  npec_pkg::result_t expected_bytes[$];
  int                errors = 0;
  bit                steady = 1'b0;
  int                stall_left = 0;

  function automatic int idle_len();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // syndrome whose odd half names pos and whose even half is its complement
  function automatic logic [31:0] flip_syndrome(input logic [npec_pkg::HALF_W-1:0] pos);
    logic [npec_pkg::HALF_W-1:0] ev;
    logic [31:0]                 s;
    ev = ~pos;
    s = $urandom;
    s[3:0] = pos[11:8];
    s[15:8] = pos[7:0];
    s[31:24] = ev[7:0];
    s[19:16] = ev[11:8];
    return s;
  endfunction

  task automatic model_word(input logic m, input logic [31:0] st, input logic [31:0] cm,
                            input logic [7:0] b);
    npec_pkg::result_t           r;
    logic [31:0]                 syn;
    logic [npec_pkg::HALF_W-1:0] half_even;
    logic [npec_pkg::HALF_W-1:0] half_odd;
    if (m == npec_pkg::MODE_ECC) begin
      syn = st ^ cm;
      half_even = {syn[19:16], syn[31:24]};
      half_odd = {syn[3:0], syn[15:8]};
      flip_due = 1'b0;
      if (st != npec_pkg::ERASED_WORD && syn != '0) begin
        if ((syn & (syn - 32'd1)) == '0) begin
          if (nfixed != npec_pkg::COUNT_MAX) nfixed++;
        end else if ((half_even ^ half_odd) != npec_pkg::HALF_MASK) begin
          if (nfailed != npec_pkg::COUNT_MAX) nfailed++;
        end else begin
          flip_due = 1'b1;
          flip_at = half_odd;
          if (nfixed != npec_pkg::COUNT_MAX) nfixed++;
        end
      end
    end else begin
      r = '0;
      r.data_out = b;
      if (flip_due && flip_at[npec_pkg::HALF_W-1:3] == byte_pos)
        r.data_out = b ^ (8'h01 << flip_at[2:0]);
      if (byte_pos == npec_pkg::BYTE_IDX_W'(npec_pkg::SECTOR_BYTES - 1)) begin
        byte_pos = '0;
        flip_due = 1'b0;
        if (sector_pos == npec_pkg::SECTOR_IDX_W'(npec_pkg::SECTORS_PER_PAGE - 1)) begin
          r.last = 1'b1;
          r.corrected_count = nfixed;
          r.uncorrectable_count = nfailed;
          r.page_status = (nfailed != '0) ? npec_pkg::STATUS_FAILED :
                          (nfixed != '0) ? npec_pkg::STATUS_CORRECTED : npec_pkg::STATUS_OK;
          sector_pos = '0;
          nfixed = '0;
          nfailed = '0;
        end else begin
          sector_pos++;
        end
      end else begin
        byte_pos++;
      end
      expected_bytes.push_back(r);
    end
  endtask

  task automatic send_word(input logic m, input logic [31:0] st, input logic [31:0] cm,
                           input logic [7:0] b);
    int gap;
    gap = idle_len();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    ecc_stored <= st;
    ecc_computed <= cm;
    data_byte <= b;
    do @(posedge clk); while (in_stall);
    model_word(m, st, cm, b);
  endtask

  task automatic send_ecc(input logic [31:0] st, input logic [31:0] cm);
    send_word(npec_pkg::MODE_ECC, st, cm, 8'($urandom));
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_word(npec_pkg::MODE_DATA, $urandom, $urandom, b);
  endtask

  task automatic send_random_bytes(input int n);
    repeat (n) send_byte(8'($urandom));
  endtask

  // runs to the end of the current sector, a whole one if at its start
  task automatic finish_sector();
    do send_byte(8'($urandom)); while (byte_pos != '0);
  endtask

  task automatic send_ecc_random();
    logic [31:0] st;
    logic [31:0] cm;
    int          r;
    st = $urandom;
    r = $urandom_range(0, 99);
    if (r < 35) cm = st ^ flip_syndrome(npec_pkg::HALF_W'($urandom_range(0, 4095)));
    else if (r < 50) cm = st ^ (32'h1 << $urandom_range(0, 31));
    else if (r < 65) cm = st;
    else if (r < 75) begin
      st = npec_pkg::ERASED_WORD;
      cm = $urandom;
    end else cm = $urandom;
    send_ecc(st, cm);
  endtask

  // first sector opens with bytes and no ecc word
  task automatic test_pass_through();
    steady = 1'b1;
    send_byte(8'h00);
    send_byte(8'hFF);
    send_random_bytes(38);
    steady = 1'b0;
  endtask

  task automatic test_ecc_inside_sector();
    send_ecc(32'h0, flip_syndrome(12'd83));
    send_random_bytes(100);
    send_ecc(32'h0, flip_syndrome(12'd2400));
    finish_sector();
  endtask

  task automatic test_ecc_word_cases();
    send_ecc(32'h0000_0000, 32'h8000_0000);
    send_ecc(npec_pkg::ERASED_WORD, 32'h0000_0000);
    send_ecc(32'h1234_5678, 32'h1234_5678);
    send_ecc(32'h0000_0000, flip_syndrome(12'h000));
    finish_sector();
  endtask

  task automatic test_several_ecc_words();
    send_ecc(32'h0, flip_syndrome(12'd41));
    send_ecc(32'h0, 32'h3);
    send_ecc(32'h0, flip_syndrome(12'd4000));
    send_ecc(32'h1234_5678, 32'h1234_5678 ^ flip_syndrome(12'hFFF));
    finish_sector();
  endtask

  task automatic test_random_words();
    int kind;
    repeat (300) begin
      steady = ($urandom_range(0, 5) == 0);
      kind = $urandom_range(0, 99);
      if (kind < 20) send_ecc_random();
      else if (kind < 30) send_word(1'($urandom), $urandom, $urandom, 8'($urandom));
      else send_byte(8'($urandom));
    end
    steady = 1'b0;
  endtask

  // saturates both counts, then ends the current sector
  task automatic test_count_saturation();
    repeat (9) send_ecc(32'h0, 32'h1 << $urandom_range(0, 31));
    repeat (9) send_ecc(32'h0, 32'h3);
    finish_sector();
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(negedge clk) begin
    if (rst || steady) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if ($urandom_range(0, 2) == 0) begin
      stall_left = idle_len();
      out_stall <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    npec_pkg::result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected word, data_out %0h last %0b", $time, data_out, last);
        errors++;
      end else begin
        want = expected_bytes.pop_front();
        check_field("data_out", want.data_out, data_out);
        check_field("last", 8'(want.last), 8'(last));
        check_field("page_status", 8'(want.page_status), 8'(page_status));
        check_field("corrected_count", 8'(want.corrected_count), 8'(corrected_count));
        check_field("uncorrectable_count", 8'(want.uncorrectable_count),
                    8'(uncorrectable_count));
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_pass_through();
    test_ecc_inside_sector();
    test_ecc_word_cases();
    test_several_ecc_words();
    test_random_words();
    test_count_saturation();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0 && expected_bytes.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule

### files.f
design/npec_pkg.sv
design/nand_page_ecc_corrector.sv
sim/testbench.sv
